### hdl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg : shared types and constants of the INI stream tokenizer
// Event and error codes, character constants and the command word that the
// front end passes to the event back end.
// ----------------------------------------------------------------------------
package ist_pkg;

	// Event kinds
	localparam logic [2:0] EV_SECTION_BYTE = 3'd0;
	localparam logic [2:0] EV_SECTION_END  = 3'd1;
	localparam logic [2:0] EV_NAME_BYTE    = 3'd2;
	localparam logic [2:0] EV_VALUE_BYTE   = 3'd3;
	localparam logic [2:0] EV_PAIR_END     = 3'd4;
	localparam logic [2:0] EV_ERROR        = 3'd5;
	localparam logic [2:0] EV_FILE_END     = 3'd6;

	// Error kinds
	localparam logic [1:0] ERR_EOF     = 2'd0;
	localparam logic [1:0] ERR_NEWLINE = 2'd1;
	localparam logic [1:0] ERR_SPACE   = 2'd2;

	// Held whitespace codes
	localparam logic [1:0] WS_SPACE = 2'd0;
	localparam logic [1:0] WS_TAB   = 2'd1;
	localparam logic [1:0] WS_CR    = 2'd2;

	// Characters
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;

	// Widths of the command word, sized for the largest configuration
	localparam int CNT_MAX_W  = 6;
	localparam int LINE_MAX_W = 32;

	typedef struct packed {
		logic       v;
		logic [2:0] kind;
		logic [7:0] data;
		logic [1:0] err;
	} ev_t;

	typedef struct packed {
		logic                  hold_v;
		logic [1:0]            hold_code;
		logic [CNT_MAX_W-1:0]  hold_idx;
		logic [CNT_MAX_W-1:0]  flush_n;
		logic [2:0]            flush_kind;
		ev_t                   ev0;
		ev_t                   ev1;
		logic [LINE_MAX_W-1:0] line;
	} cmd_t;

	// Append one event to the command's event slots
	function automatic cmd_t add_ev(cmd_t c, logic [2:0] kind, logic [7:0] data,
			logic [1:0] err);
		cmd_t r;
		r = c;
		if (!r.ev0.v) begin
			r.ev0 = '{v: 1'b1, kind: kind, data: data, err: err};
		end else begin
			r.ev1 = '{v: 1'b1, kind: kind, data: data, err: err};
		end
		return r;
	endfunction

	// Whitespace code back to its character
	function automatic logic [7:0] ws_char(logic [1:0] code);
		logic [7:0] r;
		case (code)
			WS_TAB:  r = CH_TAB;
			WS_CR:   r = CH_CR;
			default: r = CH_SPACE;
		endcase
		return r;
	endfunction

endpackage

### hdl/ist_front.sv
// ----------------------------------------------------------------------------
// ist_front : line parser
// Classifies each byte against the parse mode and builds one command word
// per accepted item: hold writes, whitespace flushes and up to two events.
// ----------------------------------------------------------------------------
module ist_front #(
	parameter int SPACE_HOLD_DEPTH = 16,
	parameter int LINE_BITS        = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                func,
	input  logic [7:0]          text_byte,
	output ist_pkg::cmd_t       cmd
);
	localparam int CW = $clog2(SPACE_HOLD_DEPTH + 1);

	typedef enum logic [3:0] {
		M_LINE, M_SECTION, M_AFTER_SECTION, M_COMMENT, M_NAME, M_QNAME,
		M_AFTER_QNAME, M_VALUE_PRE, M_VALUE, M_QVALUE, M_AFTER_QVALUE
	} mode_t;

	mode_t                mode_q, n_mode;
	logic [CW-1:0]        cnt_q, n_cnt;
	logic                 prev_q, n_prev;
	logic                 esc_q, n_esc;
	logic                 err_q, n_err;
	logic [LINE_BITS-1:0] line_q, n_line;

	logic       ws, cmt, nl;
	logic       line_go, do_hold, do_err;
	logic [1:0] err_code;
	logic       plain_v, str_v;
	logic [2:0] kind_sel;
	mode_t      close_mode;

	assign ws  = (text_byte == ist_pkg::CH_SPACE) || (text_byte == ist_pkg::CH_TAB) ||
		(text_byte == ist_pkg::CH_CR);
	assign cmt = (text_byte == ist_pkg::CH_SEMI) || (text_byte == ist_pkg::CH_HASH);
	assign nl  = (text_byte == ist_pkg::CH_LF);

	// Next state and command for the byte on the input
	always_comb begin
		ist_pkg::cmd_t c;
		c = '0;
		c.line = ist_pkg::LINE_MAX_W'(line_q);
		n_mode = mode_q;
		n_cnt = cnt_q;
		n_prev = prev_q;
		n_esc = esc_q;
		n_err = err_q;
		n_line = line_q;
		line_go = 1'b0;
		do_hold = 1'b0;
		do_err = 1'b0;
		err_code = ist_pkg::ERR_EOF;
		plain_v = 1'b0;
		str_v = 1'b0;
		kind_sel = ist_pkg::EV_NAME_BYTE;
		close_mode = M_AFTER_QNAME;

		if (func) begin
			// End of file: closing events unless an error is pending, then back to the reset state
			if (!err_q) begin
				case (mode_q)
					M_SECTION, M_QNAME, M_QVALUE: begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_ERROR, 8'd0, ist_pkg::ERR_EOF);
					end
					M_NAME, M_VALUE, M_VALUE_PRE, M_AFTER_QNAME, M_AFTER_QVALUE: begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_PAIR_END, 8'd0, 2'd0);
						c = ist_pkg::add_ev(c, ist_pkg::EV_FILE_END, 8'd0, 2'd0);
					end
					default: begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_FILE_END, 8'd0, 2'd0);
					end
				endcase
			end
			n_mode = M_LINE;
			n_cnt = '0;
			n_prev = 1'b0;
			n_esc = 1'b0;
			n_err = 1'b0;
			n_line = LINE_BITS'(1);
		end else if (!err_q) begin
			case (mode_q)
				M_SECTION: begin
					if (text_byte == ist_pkg::CH_RBRACK) begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_SECTION_END, 8'd0, 2'd0);
						n_mode = M_AFTER_SECTION;
					end else begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_SECTION_BYTE, text_byte, 2'd0);
					end
				end
				M_AFTER_SECTION: begin
					if (cmt) n_mode = M_COMMENT;
					else if (nl) n_mode = M_LINE;
					else if (!ws) begin
						do_err = 1'b1;
						err_code = ist_pkg::ERR_NEWLINE;
					end
				end
				M_COMMENT: begin
					if (nl) n_mode = M_LINE;
				end
				M_NAME: begin
					plain_v = 1'b1;
					kind_sel = ist_pkg::EV_NAME_BYTE;
				end
				M_VALUE: begin
					plain_v = 1'b1;
					kind_sel = ist_pkg::EV_VALUE_BYTE;
				end
				M_QNAME: begin
					str_v = 1'b1;
					kind_sel = ist_pkg::EV_NAME_BYTE;
					close_mode = M_AFTER_QNAME;
				end
				M_QVALUE: begin
					str_v = 1'b1;
					kind_sel = ist_pkg::EV_VALUE_BYTE;
					close_mode = M_AFTER_QVALUE;
				end
				M_AFTER_QNAME: begin
					if (cmt) begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_PAIR_END, 8'd0, 2'd0);
						n_mode = M_COMMENT;
					end else if (text_byte == ist_pkg::CH_EQ) begin
						n_mode = M_VALUE_PRE;
					end else if (!ws) begin
						// Pair ends; byte starts a new line item
						c = ist_pkg::add_ev(c, ist_pkg::EV_PAIR_END, 8'd0, 2'd0);
						line_go = 1'b1;
					end
				end
				M_VALUE_PRE: begin
					if (cmt) begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_PAIR_END, 8'd0, 2'd0);
						n_mode = M_COMMENT;
					end else if (text_byte == ist_pkg::CH_QUOTE) begin
						n_esc = 1'b0;
						n_mode = M_QVALUE;
					end else if (nl) begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_PAIR_END, 8'd0, 2'd0);
						n_mode = M_LINE;
					end else if (!ws) begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_VALUE_BYTE, text_byte, 2'd0);
						n_prev = 1'b0;
						n_cnt = '0;
						n_mode = M_VALUE;
					end
				end
				M_AFTER_QVALUE: begin
					if (cmt) begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_PAIR_END, 8'd0, 2'd0);
						n_mode = M_COMMENT;
					end else if (nl) begin
						c = ist_pkg::add_ev(c, ist_pkg::EV_PAIR_END, 8'd0, 2'd0);
						n_mode = M_LINE;
					end else if (!ws) begin
						do_err = 1'b1;
						err_code = ist_pkg::ERR_NEWLINE;
					end
				end
				default: begin
					line_go = 1'b1;
				end
			endcase

			// Start of a line item
			if (line_go) begin
				n_mode = M_LINE;
				if (text_byte == ist_pkg::CH_LBRACK) n_mode = M_SECTION;
				else if (ws || nl) n_mode = M_LINE;
				else if (cmt) n_mode = M_COMMENT;
				else if (text_byte == ist_pkg::CH_QUOTE) begin
					n_esc = 1'b0;
					n_mode = M_QNAME;
				end else if (text_byte == ist_pkg::CH_EQ) n_mode = M_VALUE_PRE;
				else begin
					c = ist_pkg::add_ev(c, ist_pkg::EV_NAME_BYTE, text_byte, 2'd0);
					n_prev = 1'b0;
					n_cnt = '0;
					n_mode = M_NAME;
				end
			end

			// Unquoted name or value
			if (plain_v) begin
				if (ws) do_hold = 1'b1;
				else if (nl) begin
					n_cnt = '0;
					c = ist_pkg::add_ev(c, ist_pkg::EV_PAIR_END, 8'd0, 2'd0);
					n_mode = M_LINE;
				end else if (mode_q == M_NAME && text_byte == ist_pkg::CH_EQ) begin
					n_cnt = '0;
					n_mode = M_VALUE_PRE;
				end else if (cmt && prev_q) begin
					n_cnt = '0;
					c = ist_pkg::add_ev(c, ist_pkg::EV_PAIR_END, 8'd0, 2'd0);
					n_mode = M_COMMENT;
				end else begin
					c.flush_n = ist_pkg::CNT_MAX_W'(cnt_q);
					c.flush_kind = kind_sel;
					n_cnt = '0;
					c = ist_pkg::add_ev(c, kind_sel, text_byte, 2'd0);
					n_prev = 1'b0;
				end
			end

			// Quoted name or value with escapes
			if (str_v) begin
				if (esc_q) begin
					n_esc = 1'b0;
					case (text_byte)
						ist_pkg::CH_BSLASH: c = ist_pkg::add_ev(c, kind_sel, ist_pkg::CH_BSLASH, 2'd0);
						8'h30: c = ist_pkg::add_ev(c, kind_sel, 8'd0, 2'd0);
						8'h61: c = ist_pkg::add_ev(c, kind_sel, 8'd7, 2'd0);
						8'h62: c = ist_pkg::add_ev(c, kind_sel, 8'd8, 2'd0);
						8'h74: c = ist_pkg::add_ev(c, kind_sel, 8'd9, 2'd0);
						8'h72: c = ist_pkg::add_ev(c, kind_sel, 8'd13, 2'd0);
						8'h6e: c = ist_pkg::add_ev(c, kind_sel, 8'd10, 2'd0);
						default: begin
							c = ist_pkg::add_ev(c, kind_sel, ist_pkg::CH_BSLASH, 2'd0);
							c = ist_pkg::add_ev(c, kind_sel, text_byte, 2'd0);
						end
					endcase
				end else if (text_byte == ist_pkg::CH_BSLASH) n_esc = 1'b1;
				else if (text_byte == ist_pkg::CH_QUOTE) n_mode = close_mode;
				else c = ist_pkg::add_ev(c, kind_sel, text_byte, 2'd0);
			end

			// Hold a whitespace byte, or overflow
			if (do_hold) begin
				if (cnt_q >= CW'(SPACE_HOLD_DEPTH)) begin
					do_err = 1'b1;
					err_code = ist_pkg::ERR_SPACE;
				end else begin
					c.hold_v = 1'b1;
					c.hold_idx = ist_pkg::CNT_MAX_W'(cnt_q);
					c.hold_code = (text_byte == ist_pkg::CH_TAB) ? ist_pkg::WS_TAB :
						((text_byte == ist_pkg::CH_CR) ? ist_pkg::WS_CR : ist_pkg::WS_SPACE);
					n_cnt = cnt_q + CW'(1);
					n_prev = 1'b1;
				end
			end

			if (do_err) begin
				c = ist_pkg::add_ev(c, ist_pkg::EV_ERROR, 8'd0, err_code);
				n_err = 1'b1;
				n_cnt = '0;
				n_esc = 1'b0;
			end

			// Line counter, saturating
			if (nl && line_q != '1) n_line = line_q + LINE_BITS'(1);
		end
		cmd = c;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_LINE;
			cnt_q <= '0;
			prev_q <= 1'b0;
			esc_q <= 1'b0;
			err_q <= 1'b0;
			line_q <= LINE_BITS'(1);
		end else if (take) begin
			mode_q <= n_mode;
			cnt_q <= n_cnt;
			prev_q <= n_prev;
			esc_q <= n_esc;
			err_q <= n_err;
			line_q <= n_line;
		end
	end

endmodule

### hdl/ist_cmd_queue.sv
// ----------------------------------------------------------------------------
// ist_cmd_queue : two-entry command queue
// Decouples the parser from the event back end.
// ----------------------------------------------------------------------------
module ist_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  ist_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd,
	output logic          avail,
	output ist_pkg::cmd_t rd_cmd
);
	ist_pkg::cmd_t slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign avail  = (cnt_q != 2'd0);
	assign rd_cmd = slot_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wr_cmd;
	end

	// Pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

### hdl/ist_back.sv
// ----------------------------------------------------------------------------
// ist_back : event sequencer
// Keeps the held whitespace, expands each command into its events one per
// cycle while the result side pops and presents them through a result register.
// ----------------------------------------------------------------------------
module ist_back #(
	parameter int SPACE_HOLD_DEPTH = 16,
	parameter int LINE_BITS        = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 avail,
	input  ist_pkg::cmd_t        cmd,
	output logic                 take_cmd,
	output logic                 empty,
	input  logic                 pop,
	output logic [2:0]           event_kind,
	output logic [7:0]           out_byte,
	output logic [1:0]           error_kind,
	output logic [LINE_BITS-1:0] line_number,
	output logic                 last
);
	localparam int PW = $clog2(SPACE_HOLD_DEPTH + 3);
	localparam int IW = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;

	logic [1:0]    hold_q [SPACE_HOLD_DEPTH];
	ist_pkg::cmd_t cur_q;
	logic          busy_q;
	logic [PW-1:0] p_q;
	logic          out_v_q;

	logic [PW-1:0] fn, total, new_total;
	logic          adv, is_last;
	ist_pkg::ev_t  item;

	assign fn        = PW'(cur_q.flush_n);
	assign total     = fn + PW'(cur_q.ev0.v) + PW'(cur_q.ev1.v);
	assign new_total = PW'(cmd.flush_n) + PW'(cmd.ev0.v) + PW'(cmd.ev1.v);
	assign take_cmd  = !busy_q && avail;
	assign adv       = busy_q && (!out_v_q || pop);
	assign is_last   = (p_q == total - PW'(1));
	assign empty     = !out_v_q;

	// Current event: held whitespace first, then the event slots
	always_comb begin
		if (p_q < fn) begin
			item = '{v: 1'b1, kind: cur_q.flush_kind,
				data: ist_pkg::ws_char(hold_q[p_q[IW-1:0]]), err: 2'd0};
		end else if (p_q == fn) begin
			item = cur_q.ev0;
		end else begin
			item = cur_q.ev1;
		end
	end

	// Held whitespace store
	always_ff @(posedge clk) begin
		if (take_cmd && cmd.hold_v) hold_q[cmd.hold_idx[IW-1:0]] <= cmd.hold_code;
	end

	// Command register
	always_ff @(posedge clk) begin
		if (take_cmd) cur_q <= cmd;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			event_kind  <= item.kind;
			out_byte    <= item.data;
			error_kind  <= item.err;
			line_number <= cur_q.line[LINE_BITS-1:0];
			last        <= is_last;
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			p_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (take_cmd) begin
				busy_q <= (new_total != '0);
				p_q <= '0;
			end else if (adv) begin
				p_q <= p_q + PW'(1);
				if (is_last) busy_q <= 1'b0;
			end
			if (adv) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end

endmodule

### hdl/ini_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// ini_stream_tokenizer : INI text to event stream
// Parser front end, command queue and event back end.
// ----------------------------------------------------------------------------
// Path: an item's command passes the queue and the command register before
// its results reach the result register. Throughput: the parser takes one
// byte a cycle while the queue has room; the back end takes no new command
// until it has sent every result of the current one, one at a time.
// Reset: arst_n clears parser state, queue and the result valid flag at once.
module ini_stream_tokenizer #(
	parameter int SPACE_HOLD_DEPTH = 16,
	parameter int LINE_BITS        = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 func,
	input  logic [7:0]           text_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic [2:0]           event_kind,
	output logic [7:0]           out_byte,
	output logic [1:0]           error_kind,
	output logic [LINE_BITS-1:0] line_number,
	output logic                 last
);
	ist_pkg::cmd_t f_cmd, q_cmd;
	logic          take, q_avail, q_rd;

	assign take = push && !full;

	ist_front #(.SPACE_HOLD_DEPTH(SPACE_HOLD_DEPTH), .LINE_BITS(LINE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .func(func), .text_byte(text_byte),
		.cmd(f_cmd)
	);

	ist_cmd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(take), .wr_cmd(f_cmd), .full(full),
		.rd(q_rd), .avail(q_avail), .rd_cmd(q_cmd)
	);

	ist_back #(.SPACE_HOLD_DEPTH(SPACE_HOLD_DEPTH), .LINE_BITS(LINE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .avail(q_avail), .cmd(q_cmd), .take_cmd(q_rd),
		.empty(empty), .pop(pop), .event_kind(event_kind), .out_byte(out_byte),
		.error_kind(error_kind), .line_number(line_number), .last(last)
	);

endmodule

### hdl/ist_checker.sv
// ----------------------------------------------------------------------------
// ist_checker : port-level checks of the INI stream tokenizer
// Watches the result side for consistent event fields.
// ----------------------------------------------------------------------------
module ist_checker #(
	parameter int LINE_BITS = 20
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic [2:0]           event_kind,
	input logic [7:0]           out_byte,
	input logic [1:0]           error_kind,
	input logic [LINE_BITS-1:0] line_number,
	input logic                 last
);
	// Non-byte events carry a zero byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (event_kind == ist_pkg::EV_SECTION_END ||
		event_kind == ist_pkg::EV_PAIR_END || event_kind == ist_pkg::EV_ERROR ||
		event_kind == ist_pkg::EV_FILE_END)) |-> (out_byte == 8'd0))
		else $error("non-byte event with data");

	// Error code only on error events
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind != ist_pkg::EV_ERROR) |-> (error_kind == 2'd0))
		else $error("error code on non-error event");

	// File end and error close the item's results
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (event_kind == ist_pkg::EV_FILE_END ||
		event_kind == ist_pkg::EV_ERROR)) |-> last)
		else $error("closing event not marked last");

	// A waiting result holds until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(out_byte) &&
		$stable(line_number)))
		else $error("result changed while waiting");

endmodule

bind ini_stream_tokenizer ist_checker #(.LINE_BITS(LINE_BITS)) u_ist_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .event_kind(event_kind),
	.out_byte(out_byte), .error_kind(error_kind), .line_number(line_number), .last(last)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : testbench of the INI stream tokenizer
// Feeds INI text byte by byte through the push side and checks every event
// that is popped against a cycle-free parser model kept in this file. A short
// table of hand-picked bytes comes first, then randomly built files made
// mostly of well-formed lines with random content, plus noise and broken
// lines. Both sides idle at random, and the event side stalls once for a long
// stretch so that the input side has to back off.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_DEPTH = 16;
	localparam int LBITS      = 20;
	localparam int MAX_EVENTS = HOLD_DEPTH + 1;
	localparam int ITEM_GOAL  = 470;
	localparam int STALL_LEN  = 300;
	localparam int WDOG_LIMIT = 3000;

	typedef enum logic [3:0] {
		P_LINE, P_SECTION, P_AFTER_SECTION, P_COMMENT, P_NAME, P_QNAME,
		P_AFTER_QNAME, P_VALUE_PRE, P_VALUE, P_QVALUE, P_AFTER_QVALUE
	} parse_state_t;

	typedef struct {
		logic [2:0]       kind;
		logic [7:0]       data;
		logic [1:0]       err;
		logic [LBITS-1:0] line;
		logic             last;
	} token_t;

	typedef struct {
		logic       eof;
		logic [7:0] data;
	} byte_item_t;

	typedef struct {
		logic       eof;
		logic [7:0] data;
		logic       chk;
		logic [2:0] kind;
		logic [7:0] ch;
		logic [1:0] err;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic func = 1'b0;
	logic [7:0] text_byte = '0;
	logic pop = 1'b0;
	logic full, empty, last;
	logic [2:0] event_kind;
	logic [7:0] out_byte;
	logic [1:0] error_kind;
	logic [LBITS-1:0] line_number;

	ini_stream_tokenizer #(.SPACE_HOLD_DEPTH(HOLD_DEPTH), .LINE_BITS(LBITS)) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.text_byte(text_byte), .empty(empty), .pop(pop), .event_kind(event_kind),
		.out_byte(out_byte), .error_kind(error_kind), .line_number(line_number),
		.last(last)
	);

	always #5 clk = ~clk;

	// Parser model state
	parse_state_t     pm_state;
	logic [1:0]       pm_ws_code [HOLD_DEPTH];
	int               pm_ws_cnt;
	bit               pm_prev_ws;
	bit               pm_escape;
	logic [LBITS-1:0] pm_line;
	bit               pm_err;
	int               pm_n;
	logic [LBITS-1:0] pm_ev_line;

	token_t     token_q[$];
	byte_item_t text_q[$];
	int  n_errors = 0;
	int  n_items = 0;
	bit  quiet = 0;
	bit  stall_req = 0;
	bit  moved_in, moved_out;

	function automatic bit is_ws(logic [7:0] c);
		return c == ist_pkg::CH_SPACE || c == ist_pkg::CH_TAB || c == ist_pkg::CH_CR;
	endfunction

	function automatic bit is_cmt(logic [7:0] c);
		return c == ist_pkg::CH_SEMI || c == ist_pkg::CH_HASH;
	endfunction

	function void pm_clear();
		pm_state = P_LINE;
		pm_ws_cnt = 0;
		pm_prev_ws = 0;
		pm_escape = 0;
		pm_line = 1;
		pm_err = 0;
	endfunction

	function void add_token(logic [2:0] k, logic [7:0] d, logic [1:0] e);
		token_t t;
		if (pm_n >= MAX_EVENTS)
			return;
		t = '{kind: k, data: d, err: e, line: pm_ev_line, last: 1'b0};
		token_q.push_back(t);
		pm_n++;
	endfunction

	function void raise_err(logic [1:0] e);
		add_token(ist_pkg::EV_ERROR, 8'h00, e);
		pm_err = 1;
		pm_ws_cnt = 0;
		pm_escape = 0;
	endfunction

	// Quoted text: escapes and the closing quote
	function void quoted_byte(logic [7:0] c, logic [2:0] k, parse_state_t close_st);
		if (pm_escape) begin
			pm_escape = 0;
			case (c)
				ist_pkg::CH_BSLASH: add_token(k, ist_pkg::CH_BSLASH, 2'd0);
				8'h30:     add_token(k, 8'h00, 2'd0);   // '0'
				8'h61:     add_token(k, 8'h07, 2'd0);   // 'a'
				8'h62:     add_token(k, 8'h08, 2'd0);   // 'b'
				8'h74:     add_token(k, ist_pkg::CH_TAB, 2'd0);  // 't'
				8'h72:     add_token(k, ist_pkg::CH_CR, 2'd0);   // 'r'
				8'h6e:     add_token(k, ist_pkg::CH_LF, 2'd0);   // 'n'
				default: begin
					add_token(k, ist_pkg::CH_BSLASH, 2'd0);
					add_token(k, c, 2'd0);
				end
			endcase
		end else if (c == ist_pkg::CH_BSLASH) begin
			pm_escape = 1;
		end else if (c == ist_pkg::CH_QUOTE) begin
			pm_state = close_st;
		end else begin
			add_token(k, c, 2'd0);
		end
	endfunction

	// Unquoted name or value: whitespace is held until a further byte
	function void bare_byte(logic [7:0] c, logic [2:0] k);
		if (is_ws(c)) begin
			if (pm_ws_cnt >= HOLD_DEPTH) begin
				raise_err(ist_pkg::ERR_SPACE);
			end else begin
				pm_ws_code[pm_ws_cnt] = c == ist_pkg::CH_TAB ? ist_pkg::WS_TAB :
					(c == ist_pkg::CH_CR ? ist_pkg::WS_CR : ist_pkg::WS_SPACE);
				pm_ws_cnt++;
				pm_prev_ws = 1;
			end
		end else if (c == ist_pkg::CH_LF) begin
			pm_ws_cnt = 0;
			add_token(ist_pkg::EV_PAIR_END, 8'h00, 2'd0);
			pm_state = P_LINE;
		end else if (k == ist_pkg::EV_NAME_BYTE && c == ist_pkg::CH_EQ) begin
			pm_ws_cnt = 0;
			pm_state = P_VALUE_PRE;
		end else if (is_cmt(c) && pm_prev_ws) begin
			pm_ws_cnt = 0;
			add_token(ist_pkg::EV_PAIR_END, 8'h00, 2'd0);
			pm_state = P_COMMENT;
		end else begin
			for (int i = 0; i < pm_ws_cnt; i++)
				add_token(k, pm_ws_code[i] == ist_pkg::WS_TAB ? ist_pkg::CH_TAB :
					(pm_ws_code[i] == ist_pkg::WS_CR ? ist_pkg::CH_CR : ist_pkg::CH_SPACE),
					2'd0);
			pm_ws_cnt = 0;
			add_token(k, c, 2'd0);
			pm_prev_ws = 0;
		end
	endfunction

	function void begin_bare(logic [7:0] c, parse_state_t st, logic [2:0] k);
		add_token(k, c, 2'd0);
		pm_prev_ws = 0;
		pm_ws_cnt = 0;
		pm_state = st;
	endfunction

	function void parse_text(logic [7:0] c);
		bit again;
		again = 1;
		while (again) begin
			again = 0;
			case (pm_state)
				P_SECTION:
					if (c == ist_pkg::CH_RBRACK) begin
						add_token(ist_pkg::EV_SECTION_END, 8'h00, 2'd0);
						pm_state = P_AFTER_SECTION;
					end else begin
						add_token(ist_pkg::EV_SECTION_BYTE, c, 2'd0);
					end
				P_AFTER_SECTION:
					if (is_cmt(c)) pm_state = P_COMMENT;
					else if (c == ist_pkg::CH_LF) pm_state = P_LINE;
					else if (!is_ws(c)) raise_err(ist_pkg::ERR_NEWLINE);
				P_COMMENT:
					if (c == ist_pkg::CH_LF) pm_state = P_LINE;
				P_NAME:   bare_byte(c, ist_pkg::EV_NAME_BYTE);
				P_VALUE:  bare_byte(c, ist_pkg::EV_VALUE_BYTE);
				P_QNAME:  quoted_byte(c, ist_pkg::EV_NAME_BYTE, P_AFTER_QNAME);
				P_QVALUE: quoted_byte(c, ist_pkg::EV_VALUE_BYTE, P_AFTER_QVALUE);
				P_AFTER_QNAME:
					if (is_cmt(c)) begin
						add_token(ist_pkg::EV_PAIR_END, 8'h00, 2'd0);
						pm_state = P_COMMENT;
					end else if (c == ist_pkg::CH_EQ) begin
						pm_state = P_VALUE_PRE;
					end else if (!is_ws(c)) begin
						// pair closes and the byte starts a new line item
						add_token(ist_pkg::EV_PAIR_END, 8'h00, 2'd0);
						pm_state = P_LINE;
						again = 1;
					end
				P_VALUE_PRE:
					if (is_cmt(c) || c == ist_pkg::CH_LF) begin
						add_token(ist_pkg::EV_PAIR_END, 8'h00, 2'd0);
						pm_state = is_cmt(c) ? P_COMMENT : P_LINE;
					end else if (c == ist_pkg::CH_QUOTE) begin
						pm_escape = 0;
						pm_state = P_QVALUE;
					end else if (!is_ws(c)) begin
						begin_bare(c, P_VALUE, ist_pkg::EV_VALUE_BYTE);
					end
				P_AFTER_QVALUE:
					if (is_cmt(c) || c == ist_pkg::CH_LF) begin
						add_token(ist_pkg::EV_PAIR_END, 8'h00, 2'd0);
						pm_state = is_cmt(c) ? P_COMMENT : P_LINE;
					end else if (!is_ws(c)) begin
						raise_err(ist_pkg::ERR_NEWLINE);
					end
				default: begin
					pm_state = P_LINE;
					if (c == ist_pkg::CH_LBRACK) pm_state = P_SECTION;
					else if (is_ws(c) || c == ist_pkg::CH_LF) ;
					else if (is_cmt(c)) pm_state = P_COMMENT;
					else if (c == ist_pkg::CH_QUOTE) begin
						pm_escape = 0;
						pm_state = P_QNAME;
					end else if (c == ist_pkg::CH_EQ) pm_state = P_VALUE_PRE;
					else begin_bare(c, P_NAME, ist_pkg::EV_NAME_BYTE);
				end
			endcase
		end
	endfunction

	// Expected events of one accepted byte or end of file
	function void predict_tokens(logic eof, logic [7:0] c);
		pm_n = 0;
		pm_ev_line = pm_line;
		if (eof) begin
			if (!pm_err) begin
				case (pm_state)
					P_SECTION, P_QNAME, P_QVALUE: raise_err(ist_pkg::ERR_EOF);
					P_NAME, P_VALUE, P_VALUE_PRE, P_AFTER_QNAME, P_AFTER_QVALUE: begin
						add_token(ist_pkg::EV_PAIR_END, 8'h00, 2'd0);
						add_token(ist_pkg::EV_FILE_END, 8'h00, 2'd0);
					end
					default: add_token(ist_pkg::EV_FILE_END, 8'h00, 2'd0);
				endcase
			end
			pm_clear();
		end else if (!pm_err) begin
			parse_text(c);
			if (c == ist_pkg::CH_LF && pm_line != '1)
				pm_line++;
		end
		if (pm_n > 0)
			token_q[token_q.size()-1].last = 1'b1;
	endfunction

	// One transfer on the push side, with random idling beforehand
	task automatic send_byte(logic eof, logic [7:0] c);
		while (!quiet && $urandom_range(0, 99) < 13) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		func <= eof;
		text_byte <= c;
		do @(posedge clk); while (full);
		predict_tokens(eof, c);
		n_items++;
	endtask

	function void put(logic [7:0] c);
		text_q.push_back('{eof: 1'b0, data: c});
	endfunction

	function logic [7:0] rand_char();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 8'($urandom_range(0, 255));
		if (r == 1) return ist_pkg::CH_SPACE;
		if (r == 2) return ist_pkg::CH_TAB;
		if (r == 3) return ist_pkg::CH_BSLASH;
		return 8'($urandom_range(8'h61, 8'h7a));
	endfunction

	function void put_ws();
		int n;
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++)
			put($urandom_range(0, 2) == 0 ? ist_pkg::CH_TAB :
				($urandom_range(0, 4) == 0 ? ist_pkg::CH_CR : ist_pkg::CH_SPACE));
	endfunction

	function void put_chars(int n, bit quoted);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			c = rand_char();
			if (quoted && c == ist_pkg::CH_QUOTE) c = 8'h71;
			put(c);
		end
	endfunction

	function void put_tail();
		put_ws();
		if ($urandom_range(0, 3) == 0) begin
			put($urandom_range(0, 1) ? ist_pkg::CH_SEMI : ist_pkg::CH_HASH);
			put_chars($urandom_range(0, 4), 0);
		end
	endfunction

	// One random file: mostly well-formed lines, some noise and broken lines
	function void build_file();
		int lines;
		int n_sp;
		lines = $urandom_range(2, 8);
		for (int l = 0; l < lines; l++) begin
			case ($urandom_range(0, 11))
				0, 1: begin
					put(ist_pkg::CH_LBRACK);
					put_chars($urandom_range(0, 5), 0);
					put(ist_pkg::CH_RBRACK);
					put_tail();
				end
				2, 3, 4: begin
					put_ws();
					put(8'($urandom_range(8'h41, 8'h5a)));
					put_chars($urandom_range(0, 5), 0);
					if ($urandom_range(0, 4) != 0) begin
						put_ws();
						put(ist_pkg::CH_EQ);
						put_ws();
						put_chars($urandom_range(0, 6), 0);
					end
					put_tail();
				end
				5, 6: begin
					put(ist_pkg::CH_QUOTE);
					put_chars($urandom_range(0, 5), 1);
					put(ist_pkg::CH_QUOTE);
					put_ws();
					if ($urandom_range(0, 3) != 0) begin
						put(ist_pkg::CH_EQ);
						put_ws();
						put(ist_pkg::CH_QUOTE);
						put_chars($urandom_range(0, 5), 1);
						put(ist_pkg::CH_QUOTE);
					end
					put_tail();
				end
				7: begin
					put($urandom_range(0, 1) ? ist_pkg::CH_SEMI : ist_pkg::CH_HASH);
					put_chars($urandom_range(0, 6), 0);
				end
				8: put_ws();
				9: begin
					// whitespace run just short of, at or just past the hold depth
					put(8'h76);
					n_sp = $urandom_range(HOLD_DEPTH - 1, HOLD_DEPTH + 1);
					for (int i = 0; i < n_sp; i++)
						put(ist_pkg::CH_SPACE);
					put(8'h77);
				end
				10: put_chars($urandom_range(1, 6), 0);
				default: begin
					// no newline after a closed section or quoted value
					if ($urandom_range(0, 1)) begin
						put(ist_pkg::CH_LBRACK);
						put(ist_pkg::CH_RBRACK);
					end else begin
						put(ist_pkg::CH_EQ);
						put(ist_pkg::CH_QUOTE);
						put(ist_pkg::CH_QUOTE);
					end
					put_ws();
					put(8'h7a);
				end
			endcase
			if (l != lines - 1 || $urandom_range(0, 2) != 0)
				put(ist_pkg::CH_LF);
		end
		text_q.push_back('{eof: 1'b1, data: 8'($urandom_range(0, 255))});
	endfunction

	localparam int DIR_N = 25;
	dir_row_t dir_tab [DIR_N] = '{
		'{1'b0, ist_pkg::CH_LBRACK, 1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, 8'hff,              1'b1, ist_pkg::EV_SECTION_BYTE, 8'hff, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_RBRACK, 1'b1, ist_pkg::EV_SECTION_END,  8'h00, ist_pkg::ERR_EOF},
		'{1'b0, 8'h78,              1'b1, ist_pkg::EV_ERROR,        8'h00,
			ist_pkg::ERR_NEWLINE},
		'{1'b0, ist_pkg::CH_LF,     1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b1, 8'hff,              1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b1, 8'h00,              1'b1, ist_pkg::EV_FILE_END,     8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_QUOTE,  1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_BSLASH, 1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_QUOTE,  1'b1, ist_pkg::EV_NAME_BYTE,    ist_pkg::CH_BSLASH,
			ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_BSLASH, 1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, 8'h6e,              1'b1, ist_pkg::EV_NAME_BYTE,    ist_pkg::CH_LF,
			ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_QUOTE,  1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_EQ,     1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, 8'h00,              1'b1, ist_pkg::EV_VALUE_BYTE,   8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_TAB,    1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_CR,     1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, 8'h76,              1'b1, ist_pkg::EV_VALUE_BYTE,   ist_pkg::CH_TAB,
			ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_SPACE,  1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_HASH,   1'b1, ist_pkg::EV_PAIR_END,     8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_LF,     1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_QUOTE,  1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b0, ist_pkg::CH_BSLASH, 1'b0, ist_pkg::EV_SECTION_BYTE, 8'h00, ist_pkg::ERR_EOF},
		'{1'b1, 8'h00,              1'b1, ist_pkg::EV_ERROR,        8'h00, ist_pkg::ERR_EOF},
		'{1'b1, 8'h00,              1'b1, ist_pkg::EV_FILE_END,     8'h00, ist_pkg::ERR_EOF}
	};

	// Stimulus
	initial begin
		int n0;
		pm_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed rows cross-check the first event of the byte
		for (int i = 0; i < DIR_N; i++) begin
			send_byte(dir_tab[i].eof, dir_tab[i].data);
			n0 = token_q.size() - pm_n;
			if (dir_tab[i].chk) begin
				if (pm_n == 0) begin
					$display("%0t: table row %0d expected kind %0d byte %h err %0d, actual none",
						$time, i, dir_tab[i].kind, dir_tab[i].ch, dir_tab[i].err);
					n_errors++;
				end else if (token_q[n0].kind != dir_tab[i].kind ||
						token_q[n0].data != dir_tab[i].ch ||
						token_q[n0].err != dir_tab[i].err) begin
					$display("%0t: table row %0d expected kind %0d byte %h err %0d",
						$time, i, dir_tab[i].kind, dir_tab[i].ch, dir_tab[i].err);
					$display("%0t:   actual kind %0d byte %h err %0d",
						$time, token_q[n0].kind, token_q[n0].data, token_q[n0].err);
					n_errors++;
				end
			end
		end

		// random files
		while (n_items < ITEM_GOAL) begin
			if (n_items > 150 && n_items < 260) quiet = 1;
			else quiet = 0;
			if (n_items > 80) stall_req = 1;
			build_file();
			while (text_q.size() > 0) begin
				byte_item_t it;
				it = text_q.pop_front();
				send_byte(it.eof, it.data);
			end
		end
		push <= 1'b0;
		quiet = 0;

		while (token_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Event side: check each transfer and pick the next pop
	initial begin
		int  hold_left;
		bit  stalled;
		token_t t;
		hold_left = 0;
		stalled = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (token_q.size() == 0) begin
					$display("%0t: unexpected event kind %0d byte %h err %0d line %0d last %b",
						$time, event_kind, out_byte, error_kind, line_number, last);
					n_errors++;
				end else begin
					t = token_q.pop_front();
					if (event_kind !== t.kind || out_byte !== t.data || error_kind !== t.err ||
							line_number !== t.line || last !== t.last) begin
						$display("%0t: expected kind %0d byte %h err %0d line %0d last %b",
							$time, t.kind, t.data, t.err, t.line, t.last);
						$display("%0t:   actual kind %0d byte %h err %0d line %0d last %b",
							$time, event_kind, out_byte, error_kind, line_number, last);
						n_errors++;
					end
				end
			end
			if (stall_req && !stalled) begin
				stalled = 1;
				hold_left = STALL_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= quiet || $urandom_range(0, 99) >= 13;
			end
		end
	end

	// Watchdog on cycles without any transfer
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			moved_in = push && !full;
			moved_out = pop && !empty;
			if (moved_in || moved_out || !arst_n) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule

### files.f
hdl/ist_pkg.sv
hdl/ist_front.sv
hdl/ist_cmd_queue.sv
hdl/ist_back.sv
hdl/ini_stream_tokenizer.sv
hdl/ist_checker.sv
dv/tb_top.sv
